@@ design/sel_pkg.sv @@
// Package with the shared types and codes of the stereo echo and low-pass effect.
`timescale 1ns / 1ps

package sel_pkg;

    // Width of a result sample on the output ports.
    localparam int OUT_BITS = 20;

    // Width of the configuration register index and of its write data.
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_BITS-1:0] REG_VOLUME_GAIN  = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PAN_LEFT     = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PAN_RIGHT    = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_EFFECT_MODE  = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LOWPASS_COEF = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ECHO_LENGTH  = 3'd5;

    // Effect mode codes; the unused code behaves as plain.
    localparam logic [1:0] MODE_PLAIN   = 2'd0;
    localparam logic [1:0] MODE_ECHO    = 2'd1;
    localparam logic [1:0] MODE_LOWPASS = 2'd2;

    // Sequencer steps of a frame, in order.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_XL,
        ST_MUL_XR,
        ST_LP_L,
        ST_LP_R,
        ST_PAN_L,
        ST_PAN_R,
        ST_OUT
    } state_t;

endpackage

@@ design/sel_mul.sv @@
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module sel_mul #(
    parameter int A_W = 21,
    parameter int B_W = 18
) (
    input  logic                        aclk,
    input  logic signed [A_W-1:0]       a_in,
    input  logic signed [B_W-1:0]       b_in,
    output logic signed [A_W+B_W-1:0]   p_out
);

    logic signed [A_W+B_W-1:0] p_reg;

    // One product per cycle, registered before any further use.
    always_ff @(posedge aclk) begin
        p_reg <= a_in * b_in;
    end

    assign p_out = p_reg;

endmodule

@@ design/stereo_echo_lowpass_effect.sv @@
// Top level of the stereo volume, feedback echo and one-pole low-pass effect.
// Each frame runs through one idle step that takes the request, six steps that
// share a single registered multiplier and one output step, where the result is
// registered. The output step waits while an earlier result is still held, which
// delays the next request.
// Reset (aresetn low, synchronous) restores the register defaults, zeroes the filter
// state and position, and empties the echo store through its fill count, with no sweep.
`timescale 1ns / 1ps

module stereo_echo_lowpass_effect
    import sel_pkg::*;
#(
    parameter int ECHO_FRAMES = 32768,
    parameter int SAMPLE_BITS = 20
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [15:0]        s_left_in,
    input  logic signed [15:0]        s_right_in,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [OUT_BITS-1:0] m_left_out,
    output logic signed [OUT_BITS-1:0] m_right_out
);

    localparam int SW     = SAMPLE_BITS;
    localparam int ADDR_W = (ECHO_FRAMES > 1) ? $clog2(ECHO_FRAMES) : 1;
    localparam int LEN_W  = 17;
    localparam int A_W    = SW + 1;
    localparam int B_W    = 18;
    localparam int P_W    = A_W + B_W;

    localparam logic signed [P_W-1:0] SMAX = {{(P_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [P_W-1:0] SMIN = ~SMAX;
    localparam logic signed [P_W-1:0] OMAX = {{(P_W-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [P_W-1:0] OMIN = ~OMAX;
    localparam logic [LEN_W-1:0] FRAMES_L = LEN_W'(ECHO_FRAMES);

    // Clamp a wide value to the internal sample range.
    function automatic logic signed [SW-1:0] sat_s(input logic signed [P_W-1:0] v);
        logic signed [SW-1:0] r;
        if (v > SMAX) begin
            r = SMAX[SW-1:0];
        end else if (v < SMIN) begin
            r = SMIN[SW-1:0];
        end else begin
            r = v[SW-1:0];
        end
        return r;
    endfunction

    // Clamp a wide value to the output range.
    function automatic logic signed [OUT_BITS-1:0] sat_o(input logic signed [P_W-1:0] v);
        logic signed [OUT_BITS-1:0] r;
        if (v > OMAX) begin
            r = OMAX[OUT_BITS-1:0];
        end else if (v < OMIN) begin
            r = OMIN[OUT_BITS-1:0];
        end else begin
            r = v[OUT_BITS-1:0];
        end
        return r;
    endfunction

    // Sign-extend a sample to the full product width.
    function automatic logic signed [P_W-1:0] ext_s(input logic signed [SW-1:0] v);
        return {{(P_W-SW){v[SW-1]}}, v};
    endfunction

    // Configuration registers.
    logic [14:0] volume_gain_reg;
    logic [15:0] pan_left_reg;
    logic [15:0] pan_right_reg;
    logic [1:0]  effect_mode_reg;
    logic [15:0] lowpass_coef_reg;
    logic [15:0] echo_length_reg;

    // Sequencer and handshake state.
    state_t state_reg, state_next;
    logic   m_valid_reg;
    logic   accept;
    logic   out_load;

    // Frame data path registers.
    logic signed [15:0]       left_in_reg, right_in_reg;
    logic signed [SW-1:0]     xl_reg, xr_reg;
    logic signed [SW-1:0]     lpl_reg, lpr_reg;
    logic signed [SW-1:0]     echo_l_reg, echo_r_reg;
    logic signed [OUT_BITS-1:0] out_l_reg;
    logic signed [OUT_BITS-1:0] m_left_reg, m_right_reg;

    // Echo store and its bookkeeping.
    logic [2*SW-1:0]   echo_mem [ECHO_FRAMES];
    logic [2*SW-1:0]   echo_rdata_reg;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W:0]   fill_reg, fill_next;

    // Shared multiplier operands and product.
    logic signed [A_W-1:0] mul_a;
    logic signed [B_W-1:0] mul_b;
    logic signed [P_W-1:0] prod;

    // Echo update values.
    logic                  entry_valid;
    logic signed [SW-1:0]  old_l, old_r;
    logic signed [SW-1:0]  echo_l_new, echo_r_new;
    logic [LEN_W-1:0]      len_eff;
    logic [LEN_W-1:0]      pos_inc;
    logic signed [SW-1:0]  pan_v;

    sel_mul #(
        .A_W (A_W),
        .B_W (B_W)
    ) u_mul (
        .aclk  (aclk),
        .a_in  (mul_a),
        .b_in  (mul_b),
        .p_out (prod)
    );

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign out_load    = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign m_valid     = m_valid_reg;
    assign m_left_out  = m_left_reg;
    assign m_right_out = m_right_reg;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volume_gain_reg  <= 15'd16384;
            pan_left_reg     <= 16'd32768;
            pan_right_reg    <= 16'd32768;
            effect_mode_reg  <= MODE_PLAIN;
            lowpass_coef_reg <= 16'd4505;
            echo_length_reg  <= 16'd22050;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_VOLUME_GAIN:  volume_gain_reg  <= cfg_wdata[14:0];
                REG_PAN_LEFT:     pan_left_reg     <= cfg_wdata;
                REG_PAN_RIGHT:    pan_right_reg    <= cfg_wdata;
                REG_EFFECT_MODE:  effect_mode_reg  <= cfg_wdata[1:0];
                REG_LOWPASS_COEF: lowpass_coef_reg <= cfg_wdata;
                REG_ECHO_LENGTH:  echo_length_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Value sent to the pan step, chosen by the effect mode.
    always_comb begin
        case (effect_mode_reg)
            MODE_ECHO:    pan_v = (state_reg == ST_PAN_L) ? echo_l_reg : echo_r_reg;
            MODE_LOWPASS: pan_v = (state_reg == ST_PAN_L) ? lpl_reg : lpr_reg;
            default:      pan_v = (state_reg == ST_PAN_L) ? xl_reg : xr_reg;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_XL: begin
                mul_a = {{(A_W-16){left_in_reg[15]}}, left_in_reg};
                mul_b = {3'b000, volume_gain_reg};
            end
            ST_MUL_XR: begin
                mul_a = {{(A_W-16){right_in_reg[15]}}, right_in_reg};
                mul_b = {3'b000, volume_gain_reg};
            end
            ST_LP_L: begin
                mul_a = {xl_reg[SW-1], xl_reg} - {lpl_reg[SW-1], lpl_reg};
                mul_b = {2'b00, lowpass_coef_reg};
            end
            ST_LP_R: begin
                mul_a = {xr_reg[SW-1], xr_reg} - {lpr_reg[SW-1], lpr_reg};
                mul_b = {2'b00, lowpass_coef_reg};
            end
            ST_PAN_L: begin
                mul_a = {pan_v[SW-1], pan_v};
                mul_b = {2'b00, pan_left_reg};
            end
            // The right pan operands stay applied while the result waits, so the
            // registered product still holds the right channel when it is loaded.
            ST_PAN_R, ST_OUT: begin
                mul_a = {pan_v[SW-1], pan_v};
                mul_b = {2'b00, pan_right_reg};
            end
            default: ;
        endcase
    end

    // Echo entry update: entries at or past the fill count read as zero.
    always_comb begin
        entry_valid = ({1'b0, pos_reg} < fill_reg);
        old_l = entry_valid ? echo_rdata_reg[SW-1:0] : '0;
        old_r = entry_valid ? echo_rdata_reg[2*SW-1:SW] : '0;
        echo_l_new = sat_s((ext_s(old_l) >>> 1) + ext_s(xl_reg));
        echo_r_new = sat_s((ext_s(old_r) >>> 1) + ext_s(xr_reg));
    end

    // Position and fill count advance; the echo length is clamped to the store depth and a zero length counts as one.
    always_comb begin
        if (echo_length_reg == 16'd0) begin
            len_eff = LEN_W'(1);
        end else if (LEN_W'(echo_length_reg) > FRAMES_L) begin
            len_eff = FRAMES_L;
        end else begin
            len_eff = LEN_W'(echo_length_reg);
        end
        pos_inc  = LEN_W'(pos_reg) + LEN_W'(1);
        pos_next = (pos_inc >= len_eff) ? '0 : pos_inc[ADDR_W-1:0];
        fill_next = ({1'b0, pos_reg} == fill_reg) ? fill_reg + 1'b1 : fill_reg;
    end

    // Next state of the frame sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   state_next = accept ? ST_MUL_XL : ST_IDLE;
            ST_MUL_XL: state_next = ST_MUL_XR;
            ST_MUL_XR: state_next = ST_LP_L;
            ST_LP_L:   state_next = ST_LP_R;
            ST_LP_R:   state_next = ST_PAN_L;
            ST_PAN_L:  state_next = ST_PAN_R;
            ST_PAN_R:  state_next = ST_OUT;
            ST_OUT:    state_next = out_load ? ST_IDLE : ST_OUT;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Filter state, echo position, fill count and output handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lpl_reg     <= '0;
            lpr_reg     <= '0;
            pos_reg     <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_LP_R) begin
                lpl_reg  <= sat_s(ext_s(lpl_reg) + (prod >>> 16));
                pos_reg  <= pos_next;
                fill_reg <= fill_next;
            end
            if (state_reg == ST_PAN_L) begin
                lpr_reg <= sat_s(ext_s(lpr_reg) + (prod >>> 16));
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the frame in progress.
    always_ff @(posedge aclk) begin
        if (accept) begin
            left_in_reg  <= s_left_in;
            right_in_reg <= s_right_in;
        end
        if (state_reg == ST_MUL_XR) begin
            xl_reg <= sat_s(prod >>> 14);
        end
        if (state_reg == ST_LP_L) begin
            xr_reg <= sat_s(prod >>> 14);
        end
        if (state_reg == ST_LP_R) begin
            echo_l_reg <= echo_l_new;
            echo_r_reg <= echo_r_new;
        end
        if (state_reg == ST_PAN_R) begin
            out_l_reg <= sat_o(prod >>> 15);
        end
        if (out_load) begin
            m_left_reg  <= out_l_reg;
            m_right_reg <= sat_o(prod >>> 15);
        end
    end

    // Echo store: read at the request, written back once per frame.
    always_ff @(posedge aclk) begin
        if (accept) begin
            echo_rdata_reg <= echo_mem[pos_reg];
        end
        if (state_reg == ST_LP_R) begin
            echo_mem[pos_reg] <= {echo_r_new, echo_l_new};
        end
    end

endmodule
